[rtl/four_digit_seven_segment_scanner_assert.svh]
// Assertion macros shared by the checker.
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH

// Checked only while out of reset.
`define FDSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset too.
`define FDSS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fdss_pkg.sv]
package fdss_pkg;

  localparam int unsigned ValueWidth  = 16;
  localparam int unsigned RemWidth    = 14;
  localparam int unsigned WeightWidth = 10;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned SegWidth    = 7;
  localparam int unsigned EnWidth     = 4;
  localparam int unsigned PosWidth    = 2;
  localparam int unsigned OutWidth    = 16;

  localparam logic [ValueWidth-1:0]  SatLimit   = 16'd9999;
  localparam logic [DigitWidth-1:0]  DigitMax   = 4'd9;
  localparam logic [PosWidth-1:0]    PosUnits   = 2'd3;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } fdss_cmd_t;

  typedef struct packed {
    logic can_sub;
    logic out_free;
  } fdss_stat_t;

  function automatic logic [SegWidth-1:0] seg_lookup(input logic [DigitWidth-1:0] d);
    logic [SegWidth-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic logic [WeightWidth-1:0] weight_of(input logic [PosWidth-1:0] p);
    logic [WeightWidth-1:0] w;
    unique case (p)
      2'd0:    w = 10'd1000;
      2'd1:    w = 10'd100;
      2'd2:    w = 10'd10;
      default: w = 10'd1;
    endcase
    return w;
  endfunction

endpackage

[rtl/fdss_ctrl.sv]
module fdss_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  fdss_pkg::fdss_stat_t stat,
  output fdss_pkg::fdss_cmd_t  cmd
);
  import fdss_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic state;
  logic state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (stat.can_sub) begin
          cmd.step = 1'b1;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/fdss_datapath.sv]
module fdss_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [fdss_pkg::ValueWidth-1:0]     display_value,
  input  fdss_pkg::fdss_cmd_t                 cmd,
  output fdss_pkg::fdss_stat_t                stat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fdss_pkg::SegWidth-1:0]       segment_pattern,
  output logic [fdss_pkg::EnWidth-1:0]        digit_enable_n,
  output logic [fdss_pkg::PosWidth-1:0]       digit_position
);
  import fdss_pkg::*;

  logic [PosWidth-1:0]    phase;
  logic [RemWidth-1:0]    remainder;
  logic [RemWidth-1:0]    work;
  logic [WeightWidth-1:0] weight;
  logic [DigitWidth-1:0]  digit;
  logic [ValueWidth-1:0]  sat_value;

  assign sat_value     = (display_value > SatLimit) ? SatLimit : display_value;
  assign stat.can_sub  = (work >= {{(RemWidth-WeightWidth){1'b0}}, weight}) &&
                         (digit != DigitMax);
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      remainder <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        phase    <= phase + 1'b1;
        m_tvalid <= 1'b1;
        if (phase != PosUnits) begin
          remainder <= work;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work   <= (phase == '0) ? sat_value[RemWidth-1:0] : remainder;
      weight <= weight_of(phase);
      digit  <= '0;
    end else if (cmd.step) begin
      work  <= work - {{(RemWidth-WeightWidth){1'b0}}, weight};
      digit <= digit + 1'b1;
    end
    if (cmd.commit) begin
      segment_pattern <= seg_lookup(digit);
      digit_enable_n  <= ~(EnWidth'(1) << phase);
      digit_position  <= phase;
    end
  end

endmodule

[rtl/four_digit_seven_segment_scanner.sv]
// Four-digit multiplexed seven-segment scanner.
// Each accepted input beat is one refresh tick and yields one output beat that
// drives one digit; digits run thousands, hundreds, tens, units, then repeat.
// Input: s_tdata[15:0] is the value to show; only the thousands tick samples
// it, and values above 9999 show as 9999.
// Output: m_tdata holds segments a..g, active-low digit strobes and the
// digit position. Hold the strobes and segments until the next beat.
// An accepted beat first loads the working registers; the digit weight is
// then subtracted repeatedly (0 to 9 times, set by the digit value), and a
// final step loads the output register. A new beat is taken while the
// previous result is still waiting in the output register.
// A stalled output holds the block in its final step until m_tready rises.
// Reset clears the digit phase and remainder; the first tick is thousands.
module four_digit_seven_segment_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] display_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [6:0] segment_pattern, [10:7] digit_enable_n,
                                 // [12:11] digit_position, [15:13] zero
);
  import fdss_pkg::*;

  fdss_cmd_t            cmd;
  fdss_stat_t           stat;
  logic [SegWidth-1:0]  segment_pattern;
  logic [EnWidth-1:0]   digit_enable_n;
  logic [PosWidth-1:0]  digit_position;

  fdss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fdss_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .display_value   (s_tdata),
    .cmd             (cmd),
    .stat            (stat),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .segment_pattern (segment_pattern),
    .digit_enable_n  (digit_enable_n),
    .digit_position  (digit_position)
  );

  assign m_tdata = {{(OutWidth-SegWidth-EnWidth-PosWidth){1'b0}},
                    digit_position, digit_enable_n, segment_pattern};

endmodule

[rtl/fdss_checker.sv]
`include "four_digit_seven_segment_scanner_assert.svh"

module fdss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import fdss_pkg::*;

  logic [PosWidth-1:0] expect_pos;
  logic [EnWidth-1:0]  strobe;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_pos <= '0;
    end else if (m_tvalid && m_tready) begin
      expect_pos <= expect_pos + 1'b1;
    end
  end

  assign strobe = ~(EnWidth'(1) << m_tdata[12:11]);

  `FDSS_ASSERT_RST(a_reset_idle, rst |=> !m_tvalid, "output valid after reset")
  `FDSS_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled beat changed")
  `FDSS_ASSERT(a_in_hold, (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)), "input moved")
  `FDSS_ASSERT(a_strobe, m_tvalid |-> (m_tdata[10:7] == strobe), "strobe does not match position")
  `FDSS_ASSERT(a_order, m_tvalid |-> (m_tdata[12:11] == expect_pos), "digit out of order")

endmodule

bind four_digit_seven_segment_scanner fdss_checker u_fdss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
